[rtl/skpt_pkg.sv]
`timescale 1ns / 1ps
package skpt_pkg;

  localparam int HASH_W   = 35;
  localparam int POW_W    = 30;
  localparam logic [POW_W-1:0] HASH_MOD = POW_W'(1000000009);
  localparam int HASH_BASE = 31;
  localparam int CHAR_W   = 7;
  localparam int REC_W    = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_OUT_W = 4;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    RS_INSERTED  = 3'd0,
    RS_FOUND     = 3'd1,
    RS_NOT_FOUND = 3'd2,
    RS_FULL      = 3'd3,
    RS_TOO_LONG  = 3'd4,
    RS_CLEARED   = 3'd5
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_HASH, S_DRAIN, S_MOD, S_HOME, S_PROBE,
    S_CMP_RD, S_CMP_CK, S_CPY_RD, S_CPY_WR, S_RESULT
  } state_t;

  typedef struct packed {
    logic  name_wr;
    logic  name_last;
    logic  op_init;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  hash_issue;
    logic  mod_step;
    logic  home_load;
    logic  probe_adv;
    logic  slot_claim;
    logic  slot_wr;
    logic  tbl_clear;
    logic  res_load;
    res_t  res_code;
    logic  res_hit;
    logic  res_found;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  ovf;
    logic  short_name;
    logic  cnt_hash_last;
    logic  cnt_mod_last;
    logic  cnt_len_last;
    logic  hash_busy;
    logic  slot_empty;
    logic  len_eq;
    logic  probe_last;
    logic  char_eq;
    logic  out_free;
  } sts_t;

  // 31^k mod (1e9+9), elaboration only
  function automatic logic [POW_W-1:0] pow_mod(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = (p * 64'(HASH_BASE)) % 64'(HASH_MOD);
    end
    return p[POW_W-1:0];
  endfunction

endpackage

[rtl/string_keyed_linear_probe_table.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tdata: char_code, record_id; tuser: kind; tlast: last
// out_     out  out_tvalid/out_tready tdata: status, slot, found_record, hash_value
//
// Each character takes one cycle while the block is idle. A last character of a long-enough
// name is followed by hashing of its last HASH_WINDOW characters, the slot reduction, a probe
// per slot, a read and a compare or write per character, and a load of the output register.
// No clearing pass after reset: slot lengths reset in flops.
// Input stalls while a request is being worked; output waits in its own register.
module string_keyed_linear_probe_table #(
  parameter int TABLE_SLOTS    = 11,
  parameter int HASH_WINDOW    = 20,
  parameter int MAX_NAME_CHARS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[6:0], record_id[22:7], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // status[2:0], slot[6:3], found_record[22:7],
                                  // hash_value[57:23], zero pad
);
  import skpt_pkg::*;

  cmd_t                  cmd;
  sts_t                  sts;
  res_t                  status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [REC_W-1:0]      found_record;
  logic [HASH_W-1:0]     hash_value;

  skpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skpt_dp #(
    .TABLE_SLOTS    (TABLE_SLOTS),
    .HASH_WINDOW    (HASH_WINDOW),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (kind_t'(in_tuser)),
    .in_char_code     (in_tdata[6:0]),
    .in_record_id     (in_tdata[22:7]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (status),
    .out_slot         (slot),
    .out_found_record (found_record),
    .out_hash_value   (hash_value)
  );

  assign out_tdata = {6'd0, hash_value, found_record, slot, status};
endmodule

[rtl/skpt_ram.sv]
`timescale 1ns / 1ps
module skpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/skpt_ctrl.sv]
`timescale 1ns / 1ps
module skpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  input  skpt_pkg::sts_t sts,
  output skpt_pkg::cmd_t cmd
);
  import skpt_pkg::*;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;
  logic   hit_r, hit_nxt;
  logic   found_r, found_nxt;
  logic   is_insert;

  assign is_insert = (sts.kind == KIND_INSERT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= RS_INSERTED;
      hit_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tlast) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        hit_nxt   = 1'b0;
        found_nxt = 1'b0;
        if (sts.ovf) begin
          res_nxt   = RS_TOO_LONG;
          state_nxt = S_RESULT;
        end else begin
          case (sts.kind)
            KIND_CLEAR: begin
              res_nxt   = RS_CLEARED;
              state_nxt = S_RESULT;
            end
            KIND_INSERT, KIND_SEARCH: begin
              state_nxt = sts.short_name ? S_PROBE : S_HASH;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH: begin
        if (sts.cnt_hash_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.hash_busy) state_nxt = S_MOD;
      end
      S_MOD: begin
        if (sts.cnt_mod_last) state_nxt = S_HOME;
      end
      S_HOME: state_nxt = S_PROBE;
      S_PROBE: begin
        if (is_insert) begin
          if (sts.slot_empty) begin
            res_nxt   = RS_INSERTED;
            hit_nxt   = 1'b1;
            state_nxt = S_CPY_RD;
          end else if (sts.probe_last) begin
            res_nxt   = RS_FULL;
            state_nxt = S_RESULT;
          end
        end else begin
          if (sts.slot_empty) begin
            res_nxt   = RS_NOT_FOUND;
            state_nxt = S_RESULT;
          end else if (sts.len_eq) begin
            state_nxt = S_CMP_RD;
          end else if (sts.probe_last) begin
            res_nxt   = RS_NOT_FOUND;
            state_nxt = S_RESULT;
          end
        end
      end
      S_CMP_RD: state_nxt = S_CMP_CK;
      S_CMP_CK: begin
        if (!sts.char_eq) begin
          if (sts.probe_last) begin
            res_nxt   = RS_NOT_FOUND;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_PROBE;
          end
        end else if (sts.cnt_len_last) begin
          res_nxt   = RS_FOUND;
          hit_nxt   = 1'b1;
          found_nxt = 1'b1;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_CMP_RD;
        end
      end
      S_CPY_RD: state_nxt = S_CPY_WR;
      S_CPY_WR: begin
        state_nxt = sts.cnt_len_last ? S_RESULT : S_CPY_RD;
      end
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_code = res_r;
    cmd.res_hit  = hit_r;
    cmd.res_found = found_r;
    in_tready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.name_wr   = in_tvalid;
        cmd.name_last = in_tvalid && in_tlast;
      end
      S_DECIDE: begin
        cmd.op_init   = 1'b1;
        cmd.cnt_clr   = 1'b1;
        cmd.tbl_clear = !sts.ovf && (sts.kind == KIND_CLEAR);
      end
      S_HASH: begin
        cmd.hash_issue = 1'b1;
        cmd.cnt_inc    = !sts.cnt_hash_last;
        cmd.cnt_clr    = sts.cnt_hash_last;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      S_HOME: cmd.home_load = 1'b1;
      S_PROBE: begin
        cmd.cnt_clr = 1'b1;
        if (is_insert) begin
          cmd.slot_claim = sts.slot_empty;
          cmd.probe_adv  = !sts.slot_empty && !sts.probe_last;
        end else begin
          cmd.probe_adv = !sts.slot_empty && !sts.len_eq && !sts.probe_last;
        end
      end
      S_CMP_CK: begin
        cmd.probe_adv = !sts.char_eq && !sts.probe_last;
        cmd.cnt_inc   = sts.char_eq && !sts.cnt_len_last;
      end
      S_CPY_WR: begin
        cmd.slot_wr = 1'b1;
        cmd.cnt_inc = !sts.cnt_len_last;
      end
      S_RESULT: cmd.res_load = sts.out_free;
      default: ;
    endcase
  end
endmodule

[rtl/skpt_dp.sv]
`timescale 1ns / 1ps
module skpt_dp #(
  parameter int TABLE_SLOTS    = 11,
  parameter int HASH_WINDOW    = 20,
  parameter int MAX_NAME_CHARS = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  skpt_pkg::cmd_t                 cmd,
  output skpt_pkg::sts_t                 sts,
  input  skpt_pkg::kind_t                in_kind,
  input  logic [skpt_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [skpt_pkg::REC_W-1:0]     in_record_id,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output skpt_pkg::res_t                 out_status,
  output logic [skpt_pkg::SLOT_OUT_W-1:0] out_slot,
  output logic [skpt_pkg::REC_W-1:0]     out_found_record,
  output logic [skpt_pkg::HASH_W-1:0]    out_hash_value
);
  import skpt_pkg::*;

  localparam int LEN_W   = $clog2(MAX_NAME_CHARS + 1);
  localparam int NAME_AW = $clog2(MAX_NAME_CHARS);
  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int TBL_D   = TABLE_SLOTS * MAX_NAME_CHARS;
  localparam int TBL_AW  = $clog2(TBL_D);
  localparam int CNT_T0  = (MAX_NAME_CHARS > HASH_WINDOW) ? MAX_NAME_CHARS : HASH_WINDOW;
  localparam int CNT_TOP = (CNT_T0 > HASH_W) ? CNT_T0 : HASH_W;
  localparam int CNT_W   = $clog2(CNT_TOP + 1);
  localparam int KW      = (HASH_WINDOW > 1) ? $clog2(HASH_WINDOW) : 1;
  localparam int PROD_W  = CHAR_W + POW_W;
  localparam int R1_W    = POW_W + 4;
  localparam int R2_W    = POW_W + 1;

  // name capture
  logic [LEN_W-1:0]  name_len_r;
  logic              name_ovf_r;
  logic [LEN_W-1:0]  op_len_r;
  logic              op_ovf_r;
  kind_t             op_kind_r;
  logic [REC_W-1:0]  op_rec_r;
  logic              has_room;

  assign has_room = (name_len_r < LEN_W'(MAX_NAME_CHARS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_len_r <= '0;
      name_ovf_r <= 1'b0;
    end else if (cmd.name_wr) begin
      if (cmd.name_last) begin
        name_len_r <= '0;
        name_ovf_r <= 1'b0;
      end else if (has_room) begin
        name_len_r <= name_len_r + 1'b1;
      end else begin
        name_ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.name_last) begin
      op_len_r  <= has_room ? name_len_r + 1'b1 : name_len_r;
      op_ovf_r  <= name_ovf_r || !has_room;
      op_kind_r <= in_kind;
      op_rec_r  <= in_record_id;
    end
  end

  // shared counter
  logic [CNT_W-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // name memory
  logic [CNT_W-1:0]   hash_addr;
  logic [NAME_AW-1:0] name_raddr;
  logic [CHAR_W-1:0]  name_rdata;

  assign hash_addr  = CNT_W'(op_len_r) - CNT_W'(HASH_WINDOW) + cnt_r;
  assign name_raddr = cmd.hash_issue ? hash_addr[NAME_AW-1:0] : cnt_r[NAME_AW-1:0];

  skpt_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_NAME_CHARS)) u_name_ram (
    .clk   (clk),
    .we    (cmd.name_wr && has_room),
    .waddr (name_len_r[NAME_AW-1:0]),
    .wdata (in_char_code),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  // hash pipeline: read, multiply, two coarse reductions, final subtract and sum
  logic [POW_W-1:0]  pow_tbl [HASH_WINDOW];
  for (genvar g = 0; g < HASH_WINDOW; g++) begin : g_pow
    assign pow_tbl[g] = pow_mod(g);
  end

  logic [3:0]        v_r;
  logic [KW-1:0]     k1_r;
  logic [PROD_W-1:0] prod_r;
  logic [R1_W-1:0]   r1_r;
  logic [R2_W-1:0]   r2_r;
  logic [HASH_W-1:0] hash_r;
  logic [PROD_W-1:0] q1m;
  logic [R1_W-1:0]   q2m;
  logic [POW_W-1:0]  term;

  assign q1m  = PROD_W'(prod_r[PROD_W-1:POW_W]) * PROD_W'(HASH_MOD);
  assign q2m  = R1_W'(r1_r[R1_W-1:POW_W]) * R1_W'(HASH_MOD);
  assign term = (r2_r >= R2_W'(HASH_MOD)) ? POW_W'(r2_r - R2_W'(HASH_MOD)) : POW_W'(r2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], cmd.hash_issue};
    end
  end

  always_ff @(posedge clk) begin
    k1_r   <= KW'(cnt_r);
    prod_r <= PROD_W'(name_rdata) * PROD_W'(pow_tbl[k1_r]);
    r1_r   <= R1_W'(prod_r - q1m);
    r2_r   <= R2_W'(r1_r - q2m);
  end

  always_ff @(posedge clk) begin
    if (cmd.op_init) begin
      hash_r <= '0;
    end else if (v_r[3]) begin
      hash_r <= hash_r + HASH_W'(term);
    end
  end

  // hash mod TABLE_SLOTS: weighted byte fold, then reciprocal multiply; three steps
  localparam int FOLD_N  = (HASH_W + 7) / 8;
  localparam int FOLD_W  = 17;
  localparam int MAGIC_K = 24;
  localparam int QP_W    = FOLD_W + MAGIC_K;
  localparam longint unsigned MAGIC =
    ((64'd1 << MAGIC_K) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);

  logic [8*FOLD_N-1:0] hash_pad;
  logic [FOLD_W-1:0]   fold_term [FOLD_N];
  logic [FOLD_W-1:0]   fold;
  logic [FOLD_W-1:0]   fold_r;
  logic [FOLD_W-1:0]   quo_r;
  logic [QP_W-1:0]     q_prod;
  logic [SLOT_W-1:0]   rem_r;

  assign hash_pad = (8*FOLD_N)'(hash_r);

  for (genvar g = 0; g < FOLD_N; g++) begin : g_fold
    // byte g weighs 2^(8g) mod TABLE_SLOTS
    localparam longint unsigned WGT = (64'd1 << (8*g)) % 64'(TABLE_SLOTS);
    assign fold_term[g] = FOLD_W'(hash_pad[8*g +: 8]) * FOLD_W'(WGT);
  end

  always_comb begin
    fold = '0;
    for (int i = 0; i < FOLD_N; i++) begin
      fold = fold + fold_term[i];
    end
  end

  assign q_prod = QP_W'(fold_r) * QP_W'(MAGIC);

  always_ff @(posedge clk) begin
    if (cmd.mod_step) begin
      fold_r <= fold;
      quo_r  <= q_prod[QP_W-1:MAGIC_K];
      rem_r  <= SLOT_W'(fold_r - quo_r * FOLD_W'(TABLE_SLOTS));
    end
  end

  // probe position
  logic [SLOT_W-1:0] s_r;
  logic [SLOT_W-1:0] pc_r;
  always_ff @(posedge clk) begin
    if (cmd.op_init) begin
      s_r  <= '0;
      pc_r <= '0;
    end else if (cmd.home_load) begin
      s_r <= rem_r;
    end else if (cmd.probe_adv) begin
      s_r  <= (s_r == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : s_r + 1'b1;
      pc_r <= pc_r + 1'b1;
    end
  end

  // slot table: lengths and records in flops, characters in memory
  logic [LEN_W-1:0] slot_len_r [TABLE_SLOTS];
  logic [REC_W-1:0] slot_rec_r [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.tbl_clear) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_len_r[i] <= '0;
      end
    end else if (cmd.slot_claim) begin
      slot_len_r[s_r] <= op_len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_claim) begin
      slot_rec_r[s_r] <= op_rec_r;
    end
  end

  logic [TBL_AW-1:0] tbl_addr;
  logic [CHAR_W-1:0] tbl_rdata;

  assign tbl_addr = TBL_AW'(s_r) * TBL_AW'(MAX_NAME_CHARS) + TBL_AW'(cnt_r);

  skpt_ram #(.WIDTH(CHAR_W), .DEPTH(TBL_D)) u_tbl_ram (
    .clk   (clk),
    .we    (cmd.slot_wr),
    .waddr (tbl_addr),
    .wdata (name_rdata),
    .raddr (tbl_addr),
    .rdata (tbl_rdata)
  );

  // output register
  logic                  out_tvalid_r;
  res_t                  status_r;
  logic [SLOT_OUT_W-1:0] slot_r;
  logic [REC_W-1:0]      found_r;
  logic [HASH_W-1:0]     hash_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status_r   <= cmd.res_code;
      slot_r     <= cmd.res_hit ? SLOT_OUT_W'(s_r) : '0;
      found_r    <= cmd.res_found ? slot_rec_r[s_r] : '0;
      hash_out_r <= hash_r;
    end
  end

  assign out_tvalid       = out_tvalid_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_found_record = found_r;
  assign out_hash_value   = hash_out_r;

  // status to controller
  localparam int MOD_STEPS = 3;

  assign sts.kind          = op_kind_r;
  assign sts.ovf           = op_ovf_r;
  assign sts.short_name    = (CNT_W'(op_len_r) < CNT_W'(HASH_WINDOW));
  assign sts.cnt_hash_last = (cnt_r == CNT_W'(HASH_WINDOW - 1));
  assign sts.cnt_mod_last  = (cnt_r == CNT_W'(MOD_STEPS - 1));
  assign sts.cnt_len_last  = (cnt_r == CNT_W'(op_len_r - 1'b1));
  assign sts.hash_busy     = |v_r;
  assign sts.slot_empty    = (slot_len_r[s_r] == '0);
  assign sts.len_eq        = (slot_len_r[s_r] == op_len_r);
  assign sts.probe_last    = (pc_r == SLOT_W'(TABLE_SLOTS - 1));
  assign sts.char_eq       = (name_rdata == tbl_rdata);
  assign sts.out_free      = !out_tvalid_r || out_tready;

  a_claim_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_claim |-> (slot_len_r[s_r] == '0))
    else $error("slot claimed while occupied");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_tvalid_r)
    else $error("result load lost");

  a_mod_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_step |-> (v_r == '0))
    else $error("hash reduction started before sum settled");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !cmd.res_load)
    else $error("result overwritten before taken");
endmodule

[test/string_keyed_linear_probe_table_test.sv]
`timescale 1ns / 1ps
module string_keyed_linear_probe_table_test;
  import skpt_pkg::*;

  localparam int SLOTS = 11;
  localparam int WINDOW = 20;
  localparam int MAXCH = 128;
  localparam longint LIMIT = 3000000;

  // first member lands in the top bits
  typedef struct packed {
    logic [34:0] hash;
    logic [15:0] rec;
    logic [3:0]  slot;
    res_t        status;
  } answer_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [63:0] out_tdata;

  string_keyed_linear_probe_table u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the table
  logic [6:0] cur_name [MAXCH];
  int cur_len;
  bit cur_ovf;
  logic [6:0] tbl_name [SLOTS][MAXCH];
  int tbl_len [SLOTS];
  logic [15:0] tbl_rec [SLOTS];

  answer_t answers_due [$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  longint cycles = 0;

  function automatic logic [34:0] name_hash();
    longint unsigned sum, pw;
    int b;
    sum = 0;
    pw = 1;
    if (cur_len < WINDOW) return '0;
    b = cur_len - WINDOW;
    for (int k = 0; k < WINDOW; k++) begin
      sum += (longint'(cur_name[b+k]) * pw) % 1000000009;
      pw = (pw * 31) % 1000000009;
    end
    return sum[34:0];
  endfunction

  function automatic bit name_at(int s);
    if (tbl_len[s] != cur_len) return 0;
    for (int i = 0; i < cur_len; i++)
      if (tbl_name[s][i] != cur_name[i]) return 0;
    return 1;
  endfunction

  // returns 1 when the character ends an operation that answers
  function automatic bit table_step(kind_t kind, logic [6:0] ch, bit lst,
                                    logic [15:0] rid, output answer_t a);
    int s;
    bit emit;
    a = '0;
    emit = 0;
    if (cur_len < MAXCH) cur_name[cur_len++] = ch;
    else cur_ovf = 1;
    if (!lst) return 0;
    emit = 1;
    if (cur_ovf) begin
      a.status = RS_TOO_LONG;
    end else if (kind == KIND_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) tbl_len[i] = 0;
      a.status = RS_CLEARED;
    end else if (kind == KIND_INSERT) begin
      a.hash = name_hash();
      s = int'(a.hash % SLOTS);
      a.status = RS_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_len[s] == 0) begin
          for (int j = 0; j < cur_len; j++) tbl_name[s][j] = cur_name[j];
          tbl_len[s] = cur_len;
          tbl_rec[s] = rid;
          a.status = RS_INSERTED;
          a.slot = 4'(s);
          break;
        end
        s = (s + 1 == SLOTS) ? 0 : s + 1;
      end
    end else if (kind == KIND_SEARCH) begin
      a.hash = name_hash();
      s = int'(a.hash % SLOTS);
      a.status = RS_NOT_FOUND;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_len[s] == 0) break;
        if (name_at(s)) begin
          a.status = RS_FOUND;
          a.slot = 4'(s);
          a.rec = tbl_rec[s];
          break;
        end
        s = (s + 1 == SLOTS) ? 0 : s + 1;
      end
    end else begin
      emit = 0;
    end
    cur_len = 0;
    cur_ovf = 0;
    return emit;
  endfunction

  task automatic send_char(kind_t kind, logic [6:0] ch, bit lst, logic [15:0] rid);
    answer_t a;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, rid, ch};
    in_tuser <= kind;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    if (table_step(kind, ch, lst, rid, a)) answers_due = {answers_due, a};
  endtask

  // name pool keeps inserts and searches hitting one another
  logic [6:0] pool [8][MAXCH];
  int pool_len [8];

  task automatic send_name(kind_t kind, int p, logic [15:0] rid);
    for (int i = 0; i < pool_len[p]; i++)
      send_char(kind, pool[p][i], i == pool_len[p] - 1, rid);
  endtask

  task automatic send_rand_name(kind_t kind, int len, logic [15:0] rid);
    for (int i = 0; i < len; i++)
      send_char(kind, 7'($urandom_range(127, 1)), i == len - 1, rid);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (answers_due.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    cycles <= cycles + 1;
    if (out_tvalid && out_tready) begin
      got = out_tdata[57:0];
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = answers_due.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d slot=%0d rec=%h hash=%h %s",
                     want.status, want.slot, want.rec, want.hash,
                     $sformatf("got st=%0d slot=%0d rec=%h hash=%h",
                               got.status, got.slot, got.rec, got.hash));
        end
      end
    end
    out_tready <= !hold_off && !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  // directed rows: kind, length (0 = pool name 0), expected status, check status only
  typedef struct {
    kind_t kind;
    int    len;
    res_t  status;
    bit    typed;
  } row_t;

  row_t rows [10] = '{
    '{KIND_SEARCH, 1,   RS_NOT_FOUND, 1},
    '{KIND_CLEAR,  1,   RS_CLEARED,   1},
    '{KIND_INSERT, 3,   RS_INSERTED,  1},
    '{KIND_INSERT, 20,  RS_INSERTED,  0},
    '{KIND_INSERT, 128, RS_INSERTED,  0},
    '{KIND_SEARCH, 129, RS_TOO_LONG,  1},
    '{KIND_CLEAR,  140, RS_TOO_LONG,  1},
    '{KIND_NONE,   5,   RS_INSERTED,  0},
    '{KIND_SEARCH, 0,   RS_FOUND,     0},
    '{KIND_SEARCH, 25,  RS_NOT_FOUND, 0}
  };

  initial begin
    int n_due;
    for (int i = 0; i < SLOTS; i++) tbl_len[i] = 0;
    cur_len = 0;
    cur_ovf = 0;
    for (int i = 0; i < 8; i++) begin
      pool_len[i] = (i < 3) ? $urandom_range(6, 1) : $urandom_range(26, 20);
      for (int j = 0; j < pool_len[i]; j++) pool[i][j] = 7'($urandom_range(127, 1));
    end
    pool[0][0] = 7'd127;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[r]) begin
      n_due = answers_due.size();
      if (rows[r].len == 0) begin
        send_name(KIND_INSERT, 0, 16'hFFFF);
        send_name(rows[r].kind, 0, 16'h0000);
      end else begin
        send_rand_name(rows[r].kind, rows[r].len, 16'($urandom));
      end
      if (rows[r].typed && answers_due.size() > n_due &&
          answers_due[$].status != rows[r].status) begin
        errors++;
        $display("predictor disagrees with row %0d", r);
      end
    end
    // fill to full, then search the full table, including long names
    for (int i = 0; i < SLOTS + 2; i++) send_name(KIND_INSERT, i % 8, 16'($urandom));
    send_rand_name(KIND_SEARCH, 22, 16'h0);
    send_rand_name(KIND_SEARCH, 2, 16'h0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 68; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 68; end
        3: begin send_idle = 9;  recv_stall = 9;  end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            for (int c = 0; c < 600; c++) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(19))
          0: send_rand_name(KIND_CLEAR, $urandom_range(3, 1), 16'h0);
          1: send_rand_name(kind_t'($urandom_range(3)), $urandom_range(135, 126),
                            16'($urandom));
          2: send_rand_name(KIND_NONE, $urandom_range(4, 1), 16'h0);
          3, 4: send_rand_name(kind_t'($urandom_range(2, 1)), $urandom_range(30, 1),
                               16'($urandom));
          5, 6, 7, 8, 9, 10: send_name(KIND_INSERT, $urandom_range(7), 16'($urandom));
          default: send_name(KIND_SEARCH, $urandom_range(7), 16'($urandom));
        endcase
      end
      drain();
    end

    if (errors == 0 && answers_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
